// ===== hdl/ssd_pkg.sv =====
package ssd_pkg;

   localparam int ByteWidth = 8;
   localparam int KindWidth = 2;

   // stitch kinds on the result channel
   localparam logic [KindWidth-1:0] KIND_NORMAL = 2'd0;
   localparam logic [KindWidth-1:0] KIND_TRIM   = 2'd1;
   localparam logic [KindWidth-1:0] KIND_STOP   = 2'd2;

   // escape lead byte and command bytes
   localparam logic [ByteWidth-1:0] ESC_LEAD    = 8'h80;
   localparam logic [ByteWidth-1:0] CMD_STOP    = 8'h01;
   localparam logic [ByteWidth-1:0] CMD_TRIM_A  = 8'h02;
   localparam logic [ByteWidth-1:0] CMD_TRIM_B  = 8'h04;
   localparam logic [ByteWidth-1:0] CMD_END     = 8'h10;

   // magnitude-127 moves, as raw bytes
   localparam logic [ByteWidth-1:0] BIG_POS     = 8'h7F;
   localparam logic [ByteWidth-1:0] BIG_NEG     = 8'h81;

   typedef struct packed {
      logic                        valid;
      logic signed [ByteWidth-1:0] move_x;
      logic signed [ByteWidth-1:0] move_y;
      logic [KindWidth-1:0]        stitch_kind;
      logic                        end_mark;
   } ssd_result_type;

   function automatic logic is_big_move(input logic [ByteWidth-1:0] b);
      return (b == BIG_POS) || (b == BIG_NEG);
   endfunction

endpackage

// ===== hdl/ssd_decode.sv =====
module ssd_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step_en,
   input  logic [ssd_pkg::ByteWidth-1:0]   data_byte,
   output ssd_pkg::ssd_result_type         result
);
   import ssd_pkg::*;

   logic                  phase_ff, phase_in;
   logic [ByteWidth-1:0]  held_ff, held_in;
   logic                  esc_pend_ff, esc_pend_in;
   logic [KindWidth-1:0]  pair_kind_ff, pair_kind_in;
   logic                  trim_next_ff, trim_next_in;
   logic                  finished_ff, finished_in;
   logic                  is_esc;

   always_comb begin
      phase_in      = phase_ff;
      held_in       = held_ff;
      esc_pend_in   = esc_pend_ff;
      pair_kind_in  = pair_kind_ff;
      trim_next_in  = trim_next_ff;
      finished_in   = finished_ff;
      is_esc        = (held_ff == ESC_LEAD);

      result.valid       = 1'b0;
      result.move_x      = held_ff;
      result.move_y      = data_byte;
      result.stitch_kind = KIND_NORMAL;
      result.end_mark    = 1'b0;

      if (!finished_ff) begin
         if (!phase_ff) begin
            held_in  = data_byte;
            phase_in = 1'b1;
         end else begin
            phase_in = 1'b0;
            if (esc_pend_ff) begin
               // escaped pair: plain move data, kind set by the escape
               esc_pend_in        = 1'b0;
               result.valid       = 1'b1;
               result.stitch_kind = pair_kind_ff;
            end else begin
               trim_next_in       = 1'b0;
               result.stitch_kind = trim_next_ff ? KIND_TRIM : KIND_NORMAL;
               if (is_esc && data_byte == CMD_STOP) begin
                  esc_pend_in  = 1'b1;
                  pair_kind_in = KIND_STOP;
               end else if (is_esc && (data_byte inside {CMD_TRIM_A, CMD_TRIM_B})) begin
                  esc_pend_in  = 1'b1;
                  pair_kind_in = KIND_TRIM;
                  trim_next_in = 1'b1;
               end else if (is_esc && data_byte == CMD_END) begin
                  finished_in        = 1'b1;
                  result.valid       = 1'b1;
                  result.move_x      = '0;
                  result.move_y      = '0;
                  result.stitch_kind = KIND_NORMAL;
                  result.end_mark    = 1'b1;
               end else begin
                  result.valid = 1'b1;
               end
            end
            // a full-scale move trims and marks the next stitch
            if (result.valid && !result.end_mark &&
                (is_big_move(held_ff) || is_big_move(data_byte))) begin
               trim_next_in       = 1'b1;
               result.stitch_kind = KIND_TRIM;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= 1'b0;
         held_ff      <= '0;
         esc_pend_ff  <= 1'b0;
         pair_kind_ff <= KIND_NORMAL;
         trim_next_ff <= 1'b0;
         finished_ff  <= 1'b0;
      end else if (step_en) begin
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         esc_pend_ff  <= esc_pend_in;
         pair_kind_ff <= pair_kind_in;
         trim_next_ff <= trim_next_in;
         finished_ff  <= finished_in;
      end
   end

   esc_not_after_end: assert property (@(posedge clock) disable iff (reset)
      finished_ff |-> !esc_pend_ff)
      else $error("escape pending after end of design");

   stop_pending_kind: assert property (@(posedge clock) disable iff (reset)
      esc_pend_ff |-> (pair_kind_ff == KIND_STOP || pair_kind_ff == KIND_TRIM))
      else $error("escape pending with normal pair kind");

   trim_escape_marks: assert property (@(posedge clock) disable iff (reset)
      (esc_pend_ff && pair_kind_ff == KIND_TRIM) |-> trim_next_ff)
      else $error("trim escape lost its follow-on trim mark");

endmodule

// ===== hdl/sew_stitch_stream_decoder.sv =====
// A byte is decoded from the byte register and its result held in the result register.
// Throughput: one byte per cycle; a pair of bytes gives at most one result.
// The rate is set by the single decode stage between the byte register and the
// result register, which both advance every cycle unless rsp_ready stalls.
// Reset (synchronous, active high) clears both registers' valid flags and the
// pairing, escape, trim and end-of-design state.
module sew_stitch_stream_decoder (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [ssd_pkg::ByteWidth-1:0]          req_data_byte,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [ssd_pkg::ByteWidth-1:0]   rsp_move_x,
   output logic signed [ssd_pkg::ByteWidth-1:0]   rsp_move_y,
   output logic [ssd_pkg::KindWidth-1:0]          rsp_stitch_kind,
   output logic                                   rsp_end_mark
);
   import ssd_pkg::*;

   // byte register
   logic                  s1_valid_ff, s1_valid_in;
   logic [ByteWidth-1:0]  s1_byte_ff;

   // result register
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [ByteWidth-1:0] rsp_x_ff, rsp_y_ff;
   logic [KindWidth-1:0]        rsp_kind_ff;
   logic                        rsp_end_ff;

   ssd_result_type dec_result;
   logic           out_free;
   logic           s1_advance;
   logic           rsp_load;

   // the result register can take a new result when empty or being drained
   assign out_free   = !rsp_valid_ff || rsp_ready;
   // advance the held byte through the decoder whenever the result side has room
   assign s1_advance = s1_valid_ff && out_free;
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign rsp_load   = s1_advance && dec_result.valid;

   ssd_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .step_en   (s1_advance),
      .data_byte (s1_byte_ff),
      .result    (dec_result)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_ready) begin
         s1_valid_in = req_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (out_free) begin
         rsp_valid_in = rsp_load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers: load on transfer only, no reset needed
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_byte_ff <= req_data_byte;
      end
      if (rsp_load) begin
         rsp_x_ff    <= dec_result.move_x;
         rsp_y_ff    <= dec_result.move_y;
         rsp_kind_ff <= dec_result.stitch_kind;
         rsp_end_ff  <= dec_result.end_mark;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_move_x      = rsp_x_ff;
   assign rsp_move_y      = rsp_y_ff;
   assign rsp_stitch_kind = rsp_kind_ff;
   assign rsp_end_mark    = rsp_end_ff;

   // end marker carries no move and normal kind
   end_mark_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_end_mark) |->
         (rsp_move_x == 0 && rsp_move_y == 0 && rsp_stitch_kind == KIND_NORMAL))
      else $error("end marker with non-zero move or kind");

   // nothing follows the end marker until reset
   nothing_after_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_end_mark) |=> !rsp_valid)
      else $error("result after end marker");

   // full-scale moves always come out as trims
   big_move_trims: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_end_mark &&
       (rsp_move_x == 8'sd127 || rsp_move_x == -8'sd127 ||
        rsp_move_y == 8'sd127 || rsp_move_y == -8'sd127)) |->
         rsp_stitch_kind == KIND_TRIM)
      else $error("magnitude-127 move not marked as trim");

   // a stalled result is not overwritten
   stall_holds_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_move_x) &&
                                     $stable(rsp_move_y) && $stable(rsp_stitch_kind)))
      else $error("stalled result changed");

endmodule

// ===== tb/sv/ssd_stitch_checker.sv =====
module ssd_stitch_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_ready,
   input  logic [ssd_pkg::ByteWidth-1:0]        req_data_byte,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   input  logic signed [ssd_pkg::ByteWidth-1:0] rsp_move_x,
   input  logic signed [ssd_pkg::ByteWidth-1:0] rsp_move_y,
   input  logic [ssd_pkg::KindWidth-1:0]        rsp_stitch_kind,
   input  logic                                 rsp_end_mark,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   checked_count
);
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   typedef enum logic [1:0] {
      PEND_NONE = 2'd0,
      PEND_STOP = 2'd1,
      PEND_TRIM = 2'd2
   } escape_pend_type;

   typedef struct packed {
      logic signed [ByteWidth-1:0] move_x;
      logic signed [ByteWidth-1:0] move_y;
      logic [KindWidth-1:0]        kind;
      logic                        end_mark;
   } stitch_type;

   // decoder state as predicted
   logic                 second_byte;
   logic [ByteWidth-1:0] lead_byte;
   escape_pend_type      escape_pend;
   logic [KindWidth-1:0] escaped_kind;
   logic                 trim_follows;
   logic                 design_done;

   stitch_type stitch_q[$];

   function automatic logic jump_byte(input logic [ByteWidth-1:0] b);
      return (b == BIG_POS) || (b == BIG_NEG);
   endfunction

   task automatic push_move(input logic [ByteWidth-1:0] bx, input logic [ByteWidth-1:0] by,
                            input logic [KindWidth-1:0] kind);
      stitch_type s;
      s.move_x   = bx;
      s.move_y   = by;
      s.kind     = kind;
      s.end_mark = 1'b0;
      // a jump of 127 on either axis trims this stitch and the next one
      if (jump_byte(bx) || jump_byte(by)) begin
         trim_follows = 1'b1;
         s.kind       = KIND_TRIM;
      end
      stitch_q.push_back(s);
   endtask

   task automatic decode_byte(input logic [ByteWidth-1:0] b);
      logic [KindWidth-1:0] kind;
      stitch_type           s;
      if (design_done) return;
      if (!second_byte) begin
         lead_byte   = b;
         second_byte = 1'b1;
         return;
      end
      second_byte = 1'b0;
      if (escape_pend != PEND_NONE) begin
         escape_pend = PEND_NONE;
         push_move(lead_byte, b, escaped_kind);
         return;
      end
      kind = KIND_NORMAL;
      if (trim_follows) begin
         kind         = KIND_TRIM;
         trim_follows = 1'b0;
      end
      if (lead_byte == ESC_LEAD) begin
         if (b == CMD_STOP) begin
            escape_pend  = PEND_STOP;
            escaped_kind = KIND_STOP;
            return;
         end
         if (b == CMD_TRIM_A || b == CMD_TRIM_B) begin
            trim_follows = 1'b1;
            escape_pend  = PEND_TRIM;
            escaped_kind = KIND_TRIM;
            return;
         end
         if (b == CMD_END) begin
            design_done = 1'b1;
            s.move_x    = '0;
            s.move_y    = '0;
            s.kind      = KIND_NORMAL;
            s.end_mark  = 1'b1;
            stitch_q.push_back(s);
            return;
         end
      end
      push_move(lead_byte, b, kind);
   endtask

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("[%0t] mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   initial begin
      fail_count    = 0;
      pending_count = 0;
      checked_count = 0;
   end

   always @(posedge clock) begin
      stitch_type want;
      if (reset) begin
         second_byte  = 1'b0;
         lead_byte    = '0;
         escape_pend  = PEND_NONE;
         escaped_kind = KIND_NORMAL;
         trim_follows = 1'b0;
         design_done  = 1'b0;
         stitch_q.delete();
      end else begin
         if (req_valid && req_ready) decode_byte(req_data_byte);
         if (rsp_valid && rsp_ready) begin
            if (stitch_q.size() == 0) begin
               report_mismatch("stitch with none pending, move_x", rsp_move_x, 0);
            end else begin
               want = stitch_q.pop_front();
               checked_count++;
               if (rsp_move_x !== want.move_x)
                  report_mismatch("move_x", rsp_move_x, want.move_x);
               if (rsp_move_y !== want.move_y)
                  report_mismatch("move_y", rsp_move_y, want.move_y);
               if (rsp_stitch_kind !== want.kind)
                  report_mismatch("stitch_kind", rsp_stitch_kind, want.kind);
               if (rsp_end_mark !== want.end_mark)
                  report_mismatch("end_mark", rsp_end_mark, want.end_mark);
            end
         end
      end
      pending_count = stitch_q.size();
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ssd_pkg::*;

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic [ByteWidth-1:0]        req_data_byte;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [ByteWidth-1:0] rsp_move_x;
   logic signed [ByteWidth-1:0] rsp_move_y;
   logic [KindWidth-1:0]        rsp_stitch_kind;
   logic                        rsp_end_mark;

   int fail_count;
   int pending_count;
   int checked_count;

   // idle rates per side in percent, changed from phase to phase
   int  snd_idle_pct;
   int  rcv_idle_pct;
   // raise to make the receiver hold off for a long stretch
   logic hold_long;

   // stream position as seen from the sender, so the end pair is only sent on purpose
   logic                 at_second;
   logic [ByteWidth-1:0] sent_lead;
   logic                 esc_open;
   logic                 allow_end;
   int                   bytes_sent;

   sew_stitch_stream_decoder u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_stitch_kind (rsp_stitch_kind),
      .rsp_end_mark    (rsp_end_mark)
   );

   ssd_stitch_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_move_x      (rsp_move_x),
      .rsp_move_y      (rsp_move_y),
      .rsp_stitch_kind (rsp_stitch_kind),
      .rsp_end_mark    (rsp_end_mark),
      .fail_count      (fail_count),
      .pending_count   (pending_count),
      .checked_count   (checked_count)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Offer one byte: optionally idle first, then hold valid and the byte until the transfer.
   // Drivers move on the falling edge; the handshake is read at the rising edge, where
   // ready still shows its value from before the edge.
   task automatic send_byte(input logic [ByteWidth-1:0] b);
      logic [ByteWidth-1:0] v;
      int                   gap;
      v = b;
      // steer a stray end pair away so that the design only ends when asked
      if (at_second && !esc_open && sent_lead == ESC_LEAD && v == CMD_END && !allow_end)
         v = v ^ 8'h20;
      if (at_second) begin
         if (esc_open)
            esc_open = 1'b0;
         else if (sent_lead == ESC_LEAD &&
                  (v == CMD_STOP || v == CMD_TRIM_A || v == CMD_TRIM_B))
            esc_open = 1'b1;
      end else begin
         sent_lead = v;
      end
      at_second = !at_second;

      if (snd_idle_pct > 0 && $urandom_range(0, 99) < snd_idle_pct) begin
         gap = $urandom_range(1, 9);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid     <= 1'b1;
      req_data_byte <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_pair(input logic [ByteWidth-1:0] bx, input logic [ByteWidth-1:0] by);
      send_byte(bx);
      send_byte(by);
   endtask

   // One random stitch sequence: mostly well-formed pairs and escapes, some stray bytes.
   task automatic send_random_sequence();
      int                   pick;
      logic [ByteWidth-1:0] a;
      // realign after a stray byte so that escapes land on pair boundaries
      if (at_second) send_byte(ByteWidth'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      a    = ByteWidth'($urandom_range(0, 255));
      if (pick < 38) begin
         send_pair(a, ByteWidth'($urandom_range(0, 255)));
      end else if (pick < 50) begin
         // jump of 127 on one randomly chosen axis
         if ($urandom_range(0, 1))
            send_pair($urandom_range(0, 1) ? BIG_POS : BIG_NEG, a);
         else
            send_pair(a, $urandom_range(0, 1) ? BIG_POS : BIG_NEG);
      end else if (pick < 60) begin
         send_pair(ESC_LEAD, CMD_STOP);
         send_pair($urandom_range(0, 3) == 0 ? ESC_LEAD : a,
                   ByteWidth'($urandom_range(0, 255)));
      end else if (pick < 70) begin
         send_pair(ESC_LEAD, $urandom_range(0, 1) ? CMD_TRIM_A : CMD_TRIM_B);
         send_pair($urandom_range(0, 2) == 0 ? ESC_LEAD : a,
                   ByteWidth'($urandom_range(0, 255)));
      end else if (pick < 80) begin
         // lead byte that looks like an escape but is mostly an ordinary -128 move
         send_pair(ESC_LEAD, a);
      end else if (pick < 92) begin
         send_pair(ByteWidth'($urandom_range(0, 8) - 4), ByteWidth'($urandom_range(0, 8) - 4));
      end else begin
         send_byte(a);
      end
   endtask

   task automatic run_random(input int upto);
      while (bytes_sent < upto) send_random_sequence();
   endtask

   // drop valid so that the last byte is not taken again, then wait for every result
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // Receiver: random stall bursts, or one long hold-off counted here when asked.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_long) begin
            rsp_ready <= 1'b0;
            repeat (80) @(negedge clock);
            hold_long = 1'b0;
            rsp_ready <= 1'b1;
         end else if (rcv_idle_pct > 0 && $urandom_range(0, 99) < rcv_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stimulus and verdict
   initial begin
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data_byte = '0;
      snd_idle_pct  = 0;
      rcv_idle_pct  = 0;
      hold_long     = 1'b0;
      at_second     = 1'b0;
      sent_lead     = '0;
      esc_open      = 1'b0;
      allow_end     = 1'b0;
      bytes_sent    = 0;
      repeat (7) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed stitches
      send_pair(ESC_LEAD, 8'hFF);        // -128 lead as a plain move
      send_pair(BIG_POS, ESC_LEAD);      // +127 jump, trims and marks the next
      send_pair(8'h00, 8'h00);           // trim from the mark
      send_pair(ESC_LEAD, CMD_STOP);     // stop escape
      send_pair(BIG_POS, CMD_STOP);      // stop stitch turned to trim by the jump
      send_pair(BIG_NEG, 8'h00);         // -127 jump, marks the next as trim
      send_pair(ESC_LEAD, CMD_STOP);     // stop escape swallows the pending trim
      send_pair(CMD_END, 8'h20);         // stop stitch
      send_pair(ESC_LEAD, CMD_TRIM_A);   // trim escape, first code
      send_pair(ESC_LEAD, CMD_END);      // escaped pair: plain data, never the end
      send_pair(ESC_LEAD, CMD_TRIM_B);   // trim escape, second code
      send_pair(ESC_LEAD, CMD_STOP);     // escaped pair: plain data, never a stop
      wait_drained();

      // Mixed idling on both sides
      snd_idle_pct = 25;
      rcv_idle_pct = 25;
      run_random(500);

      // Hold the receiver off and keep offering bytes until the block backs up
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      hold_long    = 1'b1;
      run_random(560);
      wait_drained();

      // No idling at all
      run_random(800);

      // Slow receiver, mostly eager sender
      snd_idle_pct = 10;
      rcv_idle_pct = 50;
      run_random(1000);
      wait_drained();

      // Bursty sender, nearly always-ready receiver
      snd_idle_pct = 45;
      rcv_idle_pct = 5;
      run_random(1280);

      // Last part without idling
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      run_random(1460);

      // Close any open pair and escape, then end the design; trailing bytes are dropped
      if (at_second) send_byte(8'h11);
      if (esc_open) send_pair(8'h05, 8'h06);
      allow_end = 1'b1;
      send_pair(ESC_LEAD, CMD_END);
      repeat (6) send_byte(ByteWidth'($urandom_range(0, 255)));
      @(negedge clock);
      req_valid <= 1'b0;

      wait_drained();
      repeat (10) @(negedge clock);

      $display("Covered %0d byte transfers and %0d checked stitches: plain moves, jumps,",
               bytes_sent, checked_count);
      $display("stop and trim escapes, back-pressure from a long receiver hold-off, end of design.");
      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ===== sew_stitch_stream_decoder.f =====
hdl/ssd_pkg.sv
hdl/ssd_decode.sv
hdl/sew_stitch_stream_decoder.sv
tb/sv/ssd_stitch_checker.sv
tb/sv/tb.sv
